// ===== rtl/wrd_pkg.sv =====
`default_nettype none

package wrd_pkg;

	// Field and register widths
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned IN_LIMIT_W  = 22;
	localparam int unsigned OUT_LIMIT_W = 26;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = OUT_LIMIT_W;

	// Default clamp for run counts
	localparam int unsigned MAX_RUN_DEF = 32;

	// Limit values after reset
	localparam logic [IN_LIMIT_W-1:0]  IN_LIMIT_RST  = IN_LIMIT_W'(2097152);
	localparam logic [OUT_LIMIT_W-1:0] OUT_LIMIT_RST = OUT_LIMIT_W'(33554432);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_LIMIT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = CFG_IDX_W'(1);

	// Result status codes
	typedef enum logic [1:0] {
		ST_DATA     = 2'd0,
		ST_OUT_FULL = 2'd1,
		ST_IN_LIMIT = 2'd2,
		ST_IGNORED  = 2'd3
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_RUN  = 1'b1
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
		logic busy;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_free;
		logic start_run;
		logic run_end;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/wrd_ctrl.sv =====
`default_nettype none

module wrd_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wrd_pkg::sts_t    sts,
	output wrd_pkg::cmd_t    cmd
);
	import wrd_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state: enter a run after an element item with more than one word,
	// leave it when the last word or a stop result goes out
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && sts.slot_free && sts.start_run) begin
					state_nxt = S_RUN;
				end
			end
			S_RUN: begin
				if (sts.slot_free && sts.run_end) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		cmd.busy   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = sts.slot_free;
				cmd.accept = in_valid && sts.slot_free;
			end
			S_RUN: begin
				cmd.step = sts.slot_free;
				cmd.busy = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/wrd_datapath.sv =====
`default_nettype none

module wrd_datapath #(
	parameter int unsigned MAX_RUN = wrd_pkg::MAX_RUN_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wrd_pkg::cmd_t                         cmd,
	output wrd_pkg::sts_t                         sts,
	input  wire logic [wrd_pkg::WORD_W-1:0]       word,
	input  wire logic                             start_of_stream,
	input  wire logic                             cfg_valid,
	input  wire logic [wrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wrd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [wrd_pkg::WORD_W-1:0]            data_word,
	output logic [1:0]                            status,
	output logic                                  last
);
	import wrd_pkg::*;

	localparam int unsigned PW = $clog2(MAX_RUN + 1);

	// Configuration
	logic [IN_LIMIT_W-1:0]  in_limit_q;
	logic [OUT_LIMIT_W-1:0] out_limit_q;

	// Stream state
	logic                   expect_q;
	logic [PW-1:0]          pending_q;
	logic [IN_LIMIT_W-1:0]  rd_q;
	logic [OUT_LIMIT_W-1:0] wr_q;
	logic                   stopped_q;
	logic [PW-1:0]          remain_q;
	logic [WORD_W-1:0]      elem_q;

	// Output register
	logic                   out_valid_q;
	logic [WORD_W-1:0]      out_word_q;
	status_t                out_status_q;
	logic                   out_last_q;

	// Stream state seen by an item, after an optional restart
	logic                   eff_expect;
	logic [PW-1:0]          eff_pending;
	logic [IN_LIMIT_W-1:0]  eff_rd;
	logic [OUT_LIMIT_W-1:0] eff_wr;
	logic                   eff_stopped;

	logic                   in_full;
	logic                   out_full;
	logic [PW-1:0]          acc_count;
	logic [PW-1:0]          hdr_count;
	logic [OUT_LIMIT_W-1:0] step_wr;
	logic [PW-1:0]          step_remain;
	logic [WORD_W-1:0]      step_word;

	// Next values
	logic                   expect_n;
	logic [PW-1:0]          pending_n;
	logic [IN_LIMIT_W-1:0]  rd_n;
	logic [OUT_LIMIT_W-1:0] wr_n;
	logic                   stopped_n;
	logic [PW-1:0]          remain_n;
	logic                   emit;
	logic                   do_step;
	logic [WORD_W-1:0]      emit_word;
	status_t                emit_status;
	logic                   emit_last;

	// Apply restart and share one limit compare between accept and run steps
	always_comb begin
		eff_expect  = start_of_stream ? 1'b0 : expect_q;
		eff_pending = start_of_stream ? '0 : pending_q;
		eff_rd      = start_of_stream ? '0 : rd_q;
		eff_wr      = start_of_stream ? '0 : wr_q;
		eff_stopped = start_of_stream ? 1'b0 : stopped_q;

		in_full   = eff_rd >= in_limit_q;
		acc_count = eff_expect ? eff_pending : PW'(1);
		hdr_count = (word[WORD_W-2:0] >= (WORD_W-1)'(MAX_RUN)) ? PW'(MAX_RUN)
			: word[PW-1:0];

		step_wr     = cmd.step ? wr_q : eff_wr;
		step_remain = cmd.step ? remain_q : acc_count;
		step_word   = cmd.step ? elem_q : word;
		out_full    = step_wr >= out_limit_q;

		sts.slot_free = !out_valid_q || out_ready;
		sts.start_run = !eff_stopped && !in_full && eff_expect
			&& (eff_pending > PW'(1)) && !out_full;
		sts.run_end   = out_full || (remain_q == PW'(1));
	end

	// Decide what an accepted item or a run step does
	always_comb begin
		expect_n    = expect_q;
		pending_n   = pending_q;
		rd_n        = rd_q;
		wr_n        = wr_q;
		stopped_n   = stopped_q;
		remain_n    = remain_q;
		emit        = 1'b0;
		do_step     = 1'b0;
		emit_word   = '0;
		emit_status = ST_DATA;
		emit_last   = 1'b1;

		if (cmd.accept) begin
			expect_n  = eff_expect;
			pending_n = eff_pending;
			rd_n      = eff_rd;
			wr_n      = eff_wr;
			stopped_n = eff_stopped;
			if (eff_stopped) begin
				emit        = 1'b1;
				emit_status = ST_IGNORED;
			end else if (in_full) begin
				stopped_n   = 1'b1;
				emit        = 1'b1;
				emit_status = ST_IN_LIMIT;
			end else begin
				rd_n = eff_rd + IN_LIMIT_W'(1);
				if (eff_expect) begin
					expect_n  = 1'b0;
					pending_n = '0;
					do_step   = acc_count != '0;
				end else if (word[WORD_W-1]) begin
					pending_n = hdr_count;
					expect_n  = 1'b1;
				end else begin
					do_step = 1'b1;
				end
			end
		end else if (cmd.step) begin
			do_step = 1'b1;
		end

		// Emit one run word, or the stop result when the output limit is hit
		if (do_step) begin
			emit = 1'b1;
			if (out_full) begin
				stopped_n   = 1'b1;
				emit_status = ST_OUT_FULL;
			end else begin
				wr_n      = step_wr + OUT_LIMIT_W'(1);
				emit_word = step_word;
				emit_last = step_remain == PW'(1);
				remain_n  = step_remain - PW'(1);
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_limit_q  <= IN_LIMIT_RST;
			out_limit_q <= OUT_LIMIT_RST;
			expect_q    <= 1'b0;
			pending_q   <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			stopped_q   <= 1'b0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && (cfg_index == REG_INPUT_LIMIT)) begin
				in_limit_q <= cfg_data[IN_LIMIT_W-1:0];
			end
			if (cfg_valid && (cfg_index == REG_OUTPUT_LIMIT)) begin
				out_limit_q <= cfg_data[OUT_LIMIT_W-1:0];
			end
			expect_q  <= expect_n;
			pending_q <= pending_n;
			rd_q      <= rd_n;
			wr_q      <= wr_n;
			stopped_q <= stopped_n;
			remain_q  <= remain_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			elem_q <= word;
		end
		if (emit) begin
			out_word_q   <= emit_word;
			out_status_q <= emit_status;
			out_last_q   <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign data_word = out_word_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/word_rle_decoder_unit.sv =====
// Results are registered: an item's first result, if any, shows in the cycle after it
// is accepted. A literal gives one word, a header none; a run element of count n gives
// up to n words, one per cycle from the shared emit step unless stalled; input waits.
// Output back-pressure stalls the input; a full output register blocks acceptance.
// Reset (arst_n low): counters, phase and stop flag clear; input limit 2^21 words,
// output limit 2^25 words.
`default_nettype none

module word_rle_decoder_unit #(
	parameter int unsigned MAX_RUN = wrd_pkg::MAX_RUN_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [wrd_pkg::WORD_W-1:0]       word,
	input  wire logic                             start_of_stream,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [wrd_pkg::WORD_W-1:0]            data_word,
	output logic [1:0]                            status,
	output logic                                  last,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [wrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wrd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wrd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Configuration writes land at once
	assign cfg_ready = 1'b1;

	wrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wrd_datapath #(
		.MAX_RUN (MAX_RUN)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.word            (word),
		.start_of_stream (start_of_stream),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.data_word       (data_word),
		.status          (status),
		.last            (last)
	);

	// Never load the output register while it still holds an untaken item
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept || cmd.step) |-> (!out_valid || out_ready))
		else $error("output item overwritten");

	// Input and run steps never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.step) && !(in_ready && cmd.busy))
		else $error("accept during run");

	// A run ends back in idle
	a_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.run_end) |=> !cmd.busy)
		else $error("run did not end");

	// Stop and ignore results always close their item
	a_stop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_DATA)) |-> last)
		else $error("stop result without last");

endmodule

`default_nettype wire
